// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros included by the cache unit design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/fkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc_pkg
// shared widths, status and action codes, limit reset value and cell control type of the key/value cache
// ----------------------------------------------------------------------------
package fkvc_pkg;

   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 32;
   localparam int OCC_W    = 5;
   localparam int CFG_W    = 5;

   // reset value of the eviction limit
   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd16;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_GET_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GET_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PUT_INSERT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PUT_PRESENT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PUT_EVICT   = 3'd4;

   // request action codes
   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // per-cell control from the chain controller
   typedef struct packed {
      logic valid;   // cell holds a live entry
      logic shift;   // take the right neighbor's entry
      logic load;    // take the new entry
   } cell_ctrl_type;

endpackage

// ----- design/fkvc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc channel interfaces
// request and response word channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fkvc_req_if #(
   parameter int PAYLOAD_WIDTH = 64
);
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [fkvc_pkg::KEY_W-1:0] key;
   logic [PAYLOAD_WIDTH-1:0]   payload;

   modport source (output valid, output action, output key, output payload, input ready);
   modport sink (input valid, input action, input key, input payload, output ready);
endinterface

interface fkvc_rsp_if #(
   parameter int PAYLOAD_WIDTH = 64
);
   logic                          valid;
   logic                          ready;
   logic [fkvc_pkg::STATUS_W-1:0] status;
   logic [PAYLOAD_WIDTH-1:0]      found_payload;
   logic [fkvc_pkg::TOTAL_W-1:0]  hit_total;
   logic [fkvc_pkg::TOTAL_W-1:0]  miss_total;
   logic [fkvc_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output found_payload, output hit_total,
                   output miss_total, output occupancy, input ready);
   modport sink (input valid, input status, input found_payload, input hit_total,
                 input miss_total, input occupancy, output ready);
endinterface

// ----- design/fkvc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc_cell
// one entry of the insertion-ordered chain: holds a key and payload, compares
// the key with the lookup key and shifts toward the oldest end on eviction
// ----------------------------------------------------------------------------
module fkvc_cell #(
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                          clock,
   input  fkvc_pkg::cell_ctrl_type       ctrl,
   input  logic [fkvc_pkg::KEY_W-1:0]    lookup_key,
   input  logic [PAYLOAD_WIDTH-1:0]      new_payload,
   input  logic [fkvc_pkg::KEY_W-1:0]    nbr_key,
   input  logic [PAYLOAD_WIDTH-1:0]      nbr_payload,
   output logic [fkvc_pkg::KEY_W-1:0]    key,
   output logic [PAYLOAD_WIDTH-1:0]      payload,
   output logic                          match,
   output logic [PAYLOAD_WIDTH-1:0]      hit_payload
);

   logic [fkvc_pkg::KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]   payload_ff, payload_in;

   // entry next value: new word, neighbor's entry, or hold
   always_comb begin
      priority if (ctrl.load) begin
         key_in     = lookup_key;
         payload_in = new_payload;
      end else if (ctrl.shift) begin
         key_in     = nbr_key;
         payload_in = nbr_payload;
      end else begin
         key_in     = key_ff;
         payload_in = payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   // key compare against live entry only
   assign match       = ctrl.valid && (key_ff == lookup_key);
   assign hit_payload = match ? payload_ff : '0;
   assign key         = key_ff;
   assign payload     = payload_ff;

endmodule

// ----- design/fifo_eviction_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_eviction_key_value_cache_unit
// fully associative key/payload cache with first-in-first-out replacement,
// built as a chain of entry cells ordered oldest (cell 0) to newest
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------------
//  req_ch   | in        | action, key, payload
//  rsp_ch   | out       | status, found_payload, hit_total, miss_total,
//           |           | occupancy
//  csr_*    | in        | max_entries write (no read-back)
//
//  one word per cycle unless a waiting response stalls; the response is registered, valid in the cycle after acceptance
//  lookup, eviction shift and insert all complete in the accepting cycle
//  across the cell chain, so the next word sees the updated contents
//  req_ch.ready is low only while a response waits and rsp_ch.ready is low
//  reset (synchronous) clears fill count and counters and sets the limit to MAX_ENTRIES_RESET; no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_eviction_key_value_cache_unit #(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   fkvc_req_if.sink                      req_ch,
   fkvc_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [fkvc_pkg::CFG_W-1:0]    csr_wr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > fkvc_pkg::CFG_W) ? CNT_W : fkvc_pkg::CFG_W;

   logic [fkvc_pkg::CFG_W-1:0]    max_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [fkvc_pkg::TOTAL_W-1:0]  hit_ff, hit_in;
   logic [fkvc_pkg::TOTAL_W-1:0]  miss_ff, miss_in;

   logic                          rsp_valid_ff;
   logic [fkvc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_WIDTH-1:0]      rsp_found_ff, rsp_found_in;
   logic [fkvc_pkg::OCC_W-1:0]    rsp_occ_ff;

   logic                          accept;
   logic                          is_put;
   logic                          hit;
   logic                          evict;
   logic                          insert;
   logic [CMP_W-1:0]              count_ext, max_ext, limit, occ_ext;
   logic [CNT_W-1:0]              tail;

   logic [DEPTH-1:0]              match_vec;
   logic [fkvc_pkg::KEY_W-1:0]    cell_key [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]      cell_payload [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]      cell_hit_pl [DEPTH];
   fkvc_pkg::cell_ctrl_type       cell_ctrl [DEPTH];

   // handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_put       = (req_ch.action == fkvc_pkg::ACT_PUT);

   // eviction limit clamped to the chain length
   assign count_ext = CMP_W'(count_ff);
   assign max_ext   = CMP_W'(max_ff);
   assign limit     = (max_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : max_ext;

   assign hit    = |match_vec;
   assign insert = accept && is_put && !hit;
   assign evict  = (count_ext >= limit) && (count_ff != '0);
   assign tail   = evict ? (count_ff - CNT_W'(1)) : count_ff;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [fkvc_pkg::KEY_W-1:0] nbr_key;
      logic [PAYLOAD_WIDTH-1:0]   nbr_payload;

      if (i < DEPTH - 1) begin : g_nbr
         assign nbr_key     = cell_key[i+1];
         assign nbr_payload = cell_payload[i+1];
      end else begin : g_end
         assign nbr_key     = '0;
         assign nbr_payload = '0;
      end

      assign cell_ctrl[i].valid = (CNT_W'(i) < count_ff);
      assign cell_ctrl[i].shift = insert && evict;
      assign cell_ctrl[i].load  = insert && (CNT_W'(i) == tail);

      fkvc_cell #(
         .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .lookup_key (req_ch.key),
         .new_payload(req_ch.payload),
         .nbr_key    (nbr_key),
         .nbr_payload(nbr_payload),
         .key        (cell_key[i]),
         .payload    (cell_payload[i]),
         .match      (match_vec[i]),
         .hit_payload(cell_hit_pl[i])
      );
   end

   // hit payload: keys are unique, so at most one cell drives nonzero; forced to zero on a put
   always_comb begin
      rsp_found_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rsp_found_in = rsp_found_in | cell_hit_pl[i];
      end
      if (is_put) begin
         rsp_found_in = '0;
      end
   end

   // status, counters and fill count next values
   always_comb begin
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      count_in = count_ff;
      unique case ({is_put, hit})
         2'b01: begin
            rsp_status_in = fkvc_pkg::ST_GET_HIT;
            if (hit_ff != '1) hit_in = hit_ff + fkvc_pkg::TOTAL_W'(1);
         end
         2'b00: begin
            rsp_status_in = fkvc_pkg::ST_GET_MISS;
            if (miss_ff != '1) miss_in = miss_ff + fkvc_pkg::TOTAL_W'(1);
         end
         2'b11: begin
            rsp_status_in = fkvc_pkg::ST_PUT_PRESENT;
         end
         default: begin
            rsp_status_in = evict ? fkvc_pkg::ST_PUT_EVICT : fkvc_pkg::ST_PUT_INSERT;
            count_in      = tail + CNT_W'(1);
         end
      endcase
   end

   assign occ_ext = CMP_W'(count_in);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= fkvc_pkg::MAX_ENTRIES_RESET;
         count_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) max_ff <= csr_wr_data;
         if (accept) begin
            count_ff <= count_in;
            hit_ff   <= hit_in;
            miss_ff  <= miss_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_occ_ff    <= occ_ext[fkvc_pkg::OCC_W-1:0];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.found_payload = rsp_found_ff;
   assign rsp_ch.hit_total     = hit_ff;
   assign rsp_ch.miss_total    = miss_ff;
   assign rsp_ch.occupancy     = rsp_occ_ff;

   // assertions
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_SAME(a_unique_match, clock, reset, 1'b1, $onehot0(match_vec))
   `ASSERT_NEXT(a_get_hit_status, clock, reset, accept && !is_put && hit, rsp_status_ff == fkvc_pkg::ST_GET_HIT)
   `ASSERT_NEXT(a_insert_count, clock, reset, insert, (count_ff == $past(count_ff) + CNT_W'(1)) || ((count_ff == $past(count_ff)) && ($past(count_ff) != '0)))

endmodule
